// ----- sv/c16mf_pkg.sv -----
// Shared types and constants for the CRC-16 message framer.
package c16mf_pkg;

    // Sequencer phases: waiting for an item, header burst, CRC trailer bytes.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    // One result item as it sits in the output register.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [8:0] frame_length;
        logic       orphan_error;
    } t_result;

    // Frame magic bytes, in order of transmission.
    localparam logic [7:0] C_MAGIC_0 = 8'h4E;
    localparam logic [7:0] C_MAGIC_1 = 8'h53;
    localparam logic [7:0] C_MAGIC_2 = 8'h4E;
    localparam logic [7:0] C_MAGIC_3 = 8'h47;

    // Header plus trailer bytes around the payload.
    localparam logic [8:0] C_FRAME_OVERHEAD = 9'd10;

    // CRC-16/MODBUS: reflected polynomial and initial value.
    localparam logic [15:0] C_CRC_POLY = 16'hA001;
    localparam logic [15:0] C_CRC_INIT = 16'hFFFF;

    // Item kind carried on the input side-band.
    localparam logic C_KIND_HEADER  = 1'b0;
    localparam logic C_KIND_PAYLOAD = 1'b1;

endpackage

// ----- sv/c16mf_crc_step.sv -----
// One-byte CRC-16/MODBUS update, bit-reflected, eight shift steps.
module c16mf_crc_step (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    // Fold the byte into the low end, then shift out eight bits.
    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_byte};
        for (int i = 0; i < 8; i++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ c16mf_pkg::C_CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

// ----- sv/crc16_message_framer_core.sv -----
// Top level of the CRC-16 message framer: sequencer, CRC state and output register.
//
// Input stream: each item is a header (tuser = 0) or one payload byte (tuser = 1).
// A header produces the eight header bytes 4E 53 4E 47, type, sequence, length and
// type XOR length; each payload byte is passed through.  After the last payload
// byte, or directly after a header with zero length, the two CRC-16/MODBUS bytes
// follow, high byte first.  The closing byte has tlast set and carries the total
// frame length.  A payload byte with no frame open gives one result with the
// orphan flag set in tuser.  A header always starts a fresh frame.
// Output stream: one byte per cycle while tready is high, from a single output register.
// The first result of an item is written to the output register as the item is accepted.
// Input: payload bytes are taken every cycle; a header holds input ready low while
// the rest of its header burst is emitted (and the CRC bytes with zero length), and
// the closing payload byte while the CRC bytes are emitted, because the sequencer emits one byte per cycle.
// Stall: while the receiver holds tready low the output item holds and no new
// input item is taken.  Reset clears the sequencer, the open frame and the CRC.
module crc16_message_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] msg_type, [15:8] sequence_req, [23:16] payload_length, [31:24] payload_byte
    input  logic [31:0] i_s_axis_tdata,
    // [0] kind
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] frame_byte, [16:8] frame_length, [23:17] zero
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // [0] orphan_error
    output logic        o_m_axis_tuser
);

    c16mf_pkg::t_phase  r_phase, n_phase;
    logic [2:0]         r_idx, n_idx;
    logic [15:0]        r_crc;
    logic [7:0]         r_remaining;
    logic               r_open;
    logic [7:0]         r_total;
    logic [7:0]         r_type, r_seq, r_len;
    logic               r_out_valid;
    c16mf_pkg::t_result r_out, n_res;

    logic        w_out_free, w_in_acc, w_is_hdr, w_orphan;
    logic        n_emit, w_crc_upd, w_close;
    logic [15:0] w_crc_seed, w_crc_next;
    logic [7:0]  w_crc_byte, w_hdr_byte;
    logic [7:0]  w_in_type, w_in_seq, w_in_len, w_in_pb;

    assign w_in_type = i_s_axis_tdata[7:0];
    assign w_in_seq  = i_s_axis_tdata[15:8];
    assign w_in_len  = i_s_axis_tdata[23:16];
    assign w_in_pb   = i_s_axis_tdata[31:24];

    // Handshake: a new item only when idle and the output register can take a byte.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_out_free && (r_phase == c16mf_pkg::PH_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_hdr        = (i_s_axis_tuser == c16mf_pkg::C_KIND_HEADER);
    assign w_orphan        = !r_open || (r_remaining == 8'd0);

    // Header byte for the current burst position.
    always_comb begin
        case (r_idx)
            3'd1:    w_hdr_byte = c16mf_pkg::C_MAGIC_1;
            3'd2:    w_hdr_byte = c16mf_pkg::C_MAGIC_2;
            3'd3:    w_hdr_byte = c16mf_pkg::C_MAGIC_3;
            3'd4:    w_hdr_byte = r_type;
            3'd5:    w_hdr_byte = r_seq;
            3'd6:    w_hdr_byte = r_len;
            3'd7:    w_hdr_byte = r_type ^ r_len;
            default: w_hdr_byte = c16mf_pkg::C_MAGIC_0;
        endcase
    end

    c16mf_crc_step u_crc_step (
        .i_crc  (w_crc_seed),
        .i_byte (w_crc_byte),
        .o_crc  (w_crc_next)
    );

    // Next phase and header position.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        case (r_phase)
            c16mf_pkg::PH_IDLE: begin
                if (w_in_acc) begin
                    if (w_is_hdr) begin
                        n_phase = c16mf_pkg::PH_HEADER;
                        n_idx   = 3'd1;
                    end else if (!w_orphan && (r_remaining == 8'd1)) begin
                        n_phase = c16mf_pkg::PH_CRC_HI;
                    end
                end
            end
            c16mf_pkg::PH_HEADER: begin
                if (w_out_free) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_phase = (r_len == 8'd0) ? c16mf_pkg::PH_CRC_HI
                                                  : c16mf_pkg::PH_IDLE;
                    end
                end
            end
            c16mf_pkg::PH_CRC_HI: begin
                if (w_out_free) begin
                    n_phase = c16mf_pkg::PH_CRC_LO;
                end
            end
            c16mf_pkg::PH_CRC_LO: begin
                if (w_out_free) begin
                    n_phase = c16mf_pkg::PH_IDLE;
                end
            end
            default: n_phase = c16mf_pkg::PH_IDLE;
        endcase
    end

    // Result byte, CRC input and frame close for this cycle.
    always_comb begin
        n_emit     = 1'b0;
        n_res      = '0;
        w_crc_upd  = 1'b0;
        w_close    = 1'b0;
        w_crc_seed = r_crc;
        w_crc_byte = w_in_pb;
        case (r_phase)
            c16mf_pkg::PH_IDLE: begin
                if (w_in_acc) begin
                    n_emit = 1'b1;
                    if (w_is_hdr) begin
                        w_crc_seed       = c16mf_pkg::C_CRC_INIT;
                        w_crc_byte       = c16mf_pkg::C_MAGIC_0;
                        w_crc_upd        = 1'b1;
                        n_res.frame_byte = c16mf_pkg::C_MAGIC_0;
                    end else if (w_orphan) begin
                        n_res.orphan_error = 1'b1;
                    end else begin
                        w_crc_upd        = 1'b1;
                        n_res.frame_byte = w_in_pb;
                    end
                end
            end
            c16mf_pkg::PH_HEADER: begin
                if (w_out_free) begin
                    n_emit           = 1'b1;
                    w_crc_byte       = w_hdr_byte;
                    w_crc_upd        = 1'b1;
                    n_res.frame_byte = w_hdr_byte;
                end
            end
            c16mf_pkg::PH_CRC_HI: begin
                if (w_out_free) begin
                    n_emit           = 1'b1;
                    n_res.frame_byte = r_crc[15:8];
                end
            end
            c16mf_pkg::PH_CRC_LO: begin
                if (w_out_free) begin
                    n_emit             = 1'b1;
                    w_close            = 1'b1;
                    n_res.frame_byte   = r_crc[7:0];
                    n_res.last_byte    = 1'b1;
                    n_res.frame_length = c16mf_pkg::C_FRAME_OVERHEAD + {1'b0, r_total};
                end
            end
            default: n_emit = 1'b0;
        endcase
    end

    // Control state and frame bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= c16mf_pkg::PH_IDLE;
            r_idx       <= 3'd0;
            r_crc       <= c16mf_pkg::C_CRC_INIT;
            r_remaining <= 8'd0;
            r_open      <= 1'b0;
            r_total     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_close) begin
                r_crc <= c16mf_pkg::C_CRC_INIT;
            end else if (w_crc_upd) begin
                r_crc <= w_crc_next;
            end
            if (w_in_acc && w_is_hdr) begin
                r_open      <= 1'b1;
                r_remaining <= w_in_len;
                r_total     <= w_in_len;
            end else if (w_in_acc && !w_orphan) begin
                r_remaining <= r_remaining - 8'd1;
            end else if (w_close) begin
                r_open      <= 1'b0;
                r_remaining <= 8'd0;
            end
        end
    end

    // Header fields and the output item need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_hdr) begin
            r_type <= w_in_type;
            r_seq  <= w_in_seq;
            r_len  <= w_in_len;
        end
        if (n_emit) begin
            r_out <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.frame_length, r_out.frame_byte};
    assign o_m_axis_tlast  = r_out.last_byte;
    assign o_m_axis_tuser  = r_out.orphan_error;

`ifndef SYNTHESIS
    // Input is only taken between bursts.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_phase == c16mf_pkg::PH_IDLE))
        else $error("input ready outside idle phase");

    // A header burst always belongs to an open frame.
    a_header_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == c16mf_pkg::PH_HEADER) |-> r_open)
        else $error("header burst without an open frame");

    // Closing a frame restores the CRC seed and closes the frame.
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> (r_crc == c16mf_pkg::C_CRC_INIT) && !r_open
                    && (r_phase == c16mf_pkg::PH_IDLE))
        else $error("frame close did not clear state");

    // A closing byte reports at least the header and trailer length.
    a_last_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_byte) |->
            (r_out.frame_length >= c16mf_pkg::C_FRAME_OVERHEAD))
        else $error("closing byte with short frame length");

    // An orphan result carries nothing else.
    a_orphan_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.orphan_error) |->
            (!r_out.last_byte && (r_out.frame_byte == 8'd0)))
        else $error("orphan result carries data");
`endif

endmodule
